FILE: rtl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and types of the subtractive lagged random generator:
// table geometry, lags, opcodes, controller states and the memory control
// bundle.
// ----------------------------------------------------------------------------
package slrg_pkg;

   localparam int TABLE_LEN             = 55;
   localparam int SHORT_LAG             = 24;
   localparam int LONG_LAG              = 31;
   localparam int SCATTER_STEP          = 21;
   localparam int IDX_W                 = 6;
   localparam int FRACTION_BITS_DEFAULT = 32;
   localparam int CSR_ADDR_W            = 3;
   localparam int CSR_DATA_W            = 32;
   localparam int REG_INIT_VALUE        = 0;
   localparam logic [CSR_DATA_W-1:0] INIT_VALUE_RESET = 32'd4;

   typedef enum logic {
      OP_DRAW   = 1'b0,
      OP_RESEED = 1'b1
   } opcode_type;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SEED    = 5'b00010,
      S_REFRESH = 5'b00100,
      S_FLUSH   = 5'b01000,
      S_DELIVER = 5'b10000
   } state_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
   } mem_ctl_type;

endpackage

FILE: rtl/slrg_lag_mem.sv
// ----------------------------------------------------------------------------
// slrg_lag_mem
// Lag table storage: one write port and two registered read ports. A valid
// bit per entry makes entries that were never written read as zero.
// ----------------------------------------------------------------------------
module slrg_lag_mem
   import slrg_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mem_ctl_type              mem_ctl,
   input  logic [FRACTION_BITS-1:0] wr_data,
   output logic [FRACTION_BITS-1:0] rd_data_a,
   output logic [FRACTION_BITS-1:0] rd_data_b
);

   logic [FRACTION_BITS-1:0] table_mem [TABLE_LEN];
   logic [TABLE_LEN-1:0]     vld_ff;
   logic [FRACTION_BITS-1:0] rd_a_ff;
   logic [FRACTION_BITS-1:0] rd_b_ff;
   logic                     rd_vld_a_ff;
   logic                     rd_vld_b_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         table_mem[mem_ctl.wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_a_ff <= table_mem[mem_ctl.rd_addr_a];
         rd_b_ff <= table_mem[mem_ctl.rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_vld_a_ff <= 1'b0;
         rd_vld_b_ff <= 1'b0;
      end else begin
         if (mem_ctl.wr_en) begin
            vld_ff[mem_ctl.wr_addr] <= 1'b1;
         end
         if (mem_ctl.rd_en) begin
            rd_vld_a_ff <= vld_ff[mem_ctl.rd_addr_a];
            rd_vld_b_ff <= vld_ff[mem_ctl.rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_vld_a_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_vld_b_ff ? rd_b_ff : '0;

endmodule

FILE: rtl/slrg_ctrl.sv
// ----------------------------------------------------------------------------
// slrg_ctrl
// Sequencer of the generator: position counter, warmup chain, refresh
// passes over the lag table through the memory ports, and the result
// register.
// ----------------------------------------------------------------------------
module slrg_ctrl
   import slrg_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CSR_DATA_W-1:0]    init_value,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [31:0]              req_seed,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_value,
   output mem_ctl_type              mem_ctl,
   output logic [FRACTION_BITS-1:0] mem_wdata,
   input  logic [FRACTION_BITS-1:0] mem_rdata_a,
   input  logic [FRACTION_BITS-1:0] mem_rdata_b
);

   localparam int EXT_W = (FRACTION_BITS > 32) ? FRACTION_BITS : 32;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_LEN - 1);
   localparam logic [IDX_W-1:0] SHORT_IDX = IDX_W'(SHORT_LAG);
   localparam logic [IDX_W-1:0] LONG_IDX  = IDX_W'(LONG_LAG);
   localparam logic [IDX_W:0]   STEP_SUM  = (IDX_W + 1)'(SCATTER_STEP);
   localparam logic [IDX_W:0]   LEN_SUM   = (IDX_W + 1)'(TABLE_LEN);
   localparam logic [1:0]       RESEED_PASSES = 2'd2;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         scat_ff, scat_in;
   logic [1:0]               pass_ff, pass_in;
   logic                     wrap_ff, wrap_in;
   logic [FRACTION_BITS-1:0] cur_ff, cur_in;
   logic [FRACTION_BITS-1:0] prev_ff, prev_in;
   logic                     wpipe_valid_ff, wpipe_valid_in;
   logic [IDX_W-1:0]         wpipe_addr_ff, wpipe_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_value_ff, rsp_value_in;

   logic                     req_xfer;
   logic [IDX_W:0]           pos_inc;
   logic [IDX_W:0]           scat_sum;
   logic [IDX_W-1:0]         scat_slot;
   logic [IDX_W-1:0]         partner;
   logic [EXT_W-1:0]         seed_ext;
   logic [EXT_W-1:0]         init_ext;
   logic [EXT_W-1:0]         rd_ext;
   logic                     rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign seed_ext = EXT_W'(req_seed);
   assign init_ext = EXT_W'(init_value);
   assign rd_ext   = EXT_W'(mem_rdata_a);

   assign pos_inc   = {1'b0, pos_ff} + 1'b1;
   assign scat_sum  = {1'b0, scat_ff} + STEP_SUM;
   // Scatter index k maps to slot k-1, with k of zero landing on the last slot.
   assign scat_slot = (scat_ff == '0) ? LAST_IDX : scat_ff - 1'b1;
   assign partner   = (idx_ff < SHORT_IDX) ? idx_ff + LONG_IDX : idx_ff - SHORT_IDX;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      scat_in        = scat_ff;
      pass_in        = pass_ff;
      wrap_in        = wrap_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      wpipe_valid_in = 1'b0;
      wpipe_addr_in  = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      mem_ctl        = '0;
      mem_wdata      = cur_ff;

      // A refresh write lands in the cycle after its operands were read.
      if (wpipe_valid_ff) begin
         mem_ctl.wr_en   = 1'b1;
         mem_ctl.wr_addr = wpipe_addr_ff;
         mem_wdata       = mem_rdata_a - mem_rdata_b;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_opcode == OP_RESEED) begin
                  mem_ctl.wr_en   = 1'b1;
                  mem_ctl.wr_addr = LAST_IDX;
                  mem_wdata       = seed_ext[FRACTION_BITS-1:0];
                  cur_in          = init_ext[FRACTION_BITS-1:0];
                  prev_in         = seed_ext[FRACTION_BITS-1:0];
                  scat_in         = IDX_W'(SCATTER_STEP);
                  idx_in          = IDX_W'(1);
                  pass_in         = RESEED_PASSES;
                  wrap_in         = 1'b0;
                  pos_in          = '0;
                  state_in        = S_SEED;
               end else if (pos_inc >= LEN_SUM) begin
                  pos_in   = '0;
                  idx_in   = '0;
                  pass_in  = '0;
                  wrap_in  = 1'b1;
                  state_in = S_REFRESH;
               end else begin
                  pos_in            = pos_inc[IDX_W-1:0];
                  mem_ctl.rd_en     = 1'b1;
                  mem_ctl.rd_addr_a = pos_inc[IDX_W-1:0];
                  mem_ctl.rd_addr_b = pos_inc[IDX_W-1:0];
                  state_in          = S_DELIVER;
               end
            end
         end
         S_SEED: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = scat_slot;
            mem_wdata       = cur_ff;
            cur_in          = prev_ff - cur_ff;
            prev_in         = cur_ff;
            scat_in         = (scat_sum >= LEN_SUM) ? IDX_W'(scat_sum - LEN_SUM)
                                                    : scat_sum[IDX_W-1:0];
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_REFRESH;
            end
         end
         S_REFRESH: begin
            mem_ctl.rd_en     = 1'b1;
            mem_ctl.rd_addr_a = idx_ff;
            mem_ctl.rd_addr_b = partner;
            wpipe_valid_in    = 1'b1;
            wpipe_addr_in     = idx_ff;
            idx_in            = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               if (pass_ff == '0) begin
                  state_in = S_FLUSH;
               end else begin
                  pass_in = pass_ff - 1'b1;
               end
            end
         end
         S_FLUSH: begin
            // The last refresh write completes here; a wrapped draw reads now.
            if (wrap_ff) begin
               mem_ctl.rd_en     = 1'b1;
               mem_ctl.rd_addr_a = pos_ff;
               mem_ctl.rd_addr_b = pos_ff;
               state_in          = S_DELIVER;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ext[31:0];
               wrap_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_ff         <= '0;
         idx_ff         <= '0;
         scat_ff        <= '0;
         pass_ff        <= '0;
         wrap_ff        <= 1'b0;
         wpipe_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         idx_ff         <= idx_in;
         scat_ff        <= scat_in;
         pass_ff        <= pass_in;
         wrap_ff        <= wrap_in;
         wpipe_valid_ff <= wpipe_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      wpipe_addr_ff <= wpipe_addr_in;
      rsp_value_ff  <= rsp_value_in;
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.wr_en && mem_ctl.rd_en) |->
         (mem_ctl.wr_addr != mem_ctl.rd_addr_a && mem_ctl.wr_addr != mem_ctl.rd_addr_b))
      else $error("table entry read in the cycle it is written");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_IDX)
      else $error("position left the table");

   a_reseed_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_opcode == OP_RESEED) |=> (state_ff == S_SEED && pos_ff == '0))
      else $error("reseed did not start the warmup chain");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DELIVER))
      else $error("result loaded outside of delivery");

endmodule

FILE: rtl/subtractive_lagged_random_generator.sv
// ----------------------------------------------------------------------------
// subtractive_lagged_random_generator
// Subtractive lagged random generator (lags 55 and 24) over a 55-word table
// of fixed-point fractions, with an APB-style register for the warmup start.
//
//   channel  direction  signals                          payload
//   req      in         req_valid / req_ready            req_opcode, req_seed
//   rsp      out        rsp_valid / rsp_ready            rsp_value
//   csr      in/out     csr_psel/penable/pwrite/pready   csr_paddr, csr_pwdata,
//                                                         csr_prdata
//
// In a draw, the transfer cycle issues the table read and the deliver state
// then loads the result register once it is free. Every 55th draw wraps and
// first runs one refresh pass through the two read ports, one entry per cycle.
// A reseed runs 54 warmup writes and three refresh passes. The table reads
// as zero after reset through per-entry valid bits, so no clearing pass is
// needed. A stalled result holds in the output register while the next
// request transfer is already taken.
// ----------------------------------------------------------------------------
module subtractive_lagged_random_generator
   import slrg_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [31:0]           req_seed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CSR_DATA_W-1:0]    init_ff, init_in;
   logic                     csr_hit;
   mem_ctl_type              mem_ctl;
   logic [FRACTION_BITS-1:0] mem_wdata;
   logic [FRACTION_BITS-1:0] mem_rdata_a;
   logic [FRACTION_BITS-1:0] mem_rdata_b;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == 1'(REG_INIT_VALUE));
   assign csr_prdata = csr_hit ? init_ff : '0;

   always_comb begin
      init_in = init_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         init_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= INIT_VALUE_RESET;
      end else begin
         init_ff <= init_in;
      end
   end

   slrg_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .init_value (init_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_seed   (req_seed),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .mem_ctl    (mem_ctl),
      .mem_wdata  (mem_wdata),
      .mem_rdata_a(mem_rdata_a),
      .mem_rdata_b(mem_rdata_b)
   );

   slrg_lag_mem #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_ctl  (mem_ctl),
      .wr_data  (mem_wdata),
      .rd_data_a(mem_rdata_a),
      .rd_data_b(mem_rdata_b)
   );

endmodule

FILE: tb/slrg_draw_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_draw_check
// Watches the request, result and register ports of the lagged generator,
// keeps its own copy of the 55-word table, the position and the warmup
// register, and compares every result transfer with the predicted draw.
// ----------------------------------------------------------------------------
module slrg_draw_check
   import slrg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [31:0]           req_seed,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [31:0]           rsp_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   output int                    fail_count,
   output int                    draws_pending
);

   localparam logic [CSR_ADDR_W-1:0] WARMUP_ADDR = CSR_ADDR_W'(4 * REG_INIT_VALUE);

   logic [31:0] lag_words [0:TABLE_LEN-1];
   logic [5:0]  draw_pos;
   logic [31:0] warmup_start;
   logic [31:0] expected_values [$];

   task automatic refresh_lags();
      int j;
      for (j = 0; j < SHORT_LAG; j++)
         lag_words[j] = lag_words[j] - lag_words[j + LONG_LAG];
      for (j = SHORT_LAG; j < TABLE_LEN; j++)
         lag_words[j] = lag_words[j] - lag_words[j - SHORT_LAG];
   endtask

   // The warmup chain fills the table in scattered order, each slot taking
   // the running difference of the two previous chain values.
   task automatic reseed_lags(input logic [31:0] seed);
      logic [31:0] cur;
      logic [31:0] prev;
      int          j;
      int          slot;
      cur = warmup_start;
      prev = seed;
      lag_words[TABLE_LEN-1] = seed;
      for (j = 1; j < TABLE_LEN; j++) begin
         slot = (SCATTER_STEP * j) % TABLE_LEN;
         slot = (slot == 0) ? TABLE_LEN - 1 : slot - 1;
         lag_words[slot] = cur;
         cur = prev - cur;
         prev = lag_words[slot];
      end
      refresh_lags();
      refresh_lags();
      refresh_lags();
      draw_pos = '0;
   endtask

   task automatic predict_draw();
      draw_pos = draw_pos + 6'd1;
      if (draw_pos >= TABLE_LEN) begin
         draw_pos = '0;
         refresh_lags();
      end
      expected_values.push_back(lag_words[draw_pos]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_LEN; i++)
            lag_words[i] = '0;
         draw_pos = '0;
         warmup_start = INIT_VALUE_RESET;
         expected_values.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == WARMUP_ADDR) begin
            if (csr_pwrite) begin
               warmup_start = csr_pwdata;
            end else if (csr_prdata !== warmup_start) begin
               $error("initial_value readback mismatch: expected %h, actual %h",
                      warmup_start, csr_prdata);
               fail_count++;
            end
         end
         // Results are retired before new requests so that a result can
         // never be matched against the draw accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $error("value transfer with no draw outstanding: actual %h", rsp_value);
               fail_count++;
            end else if (rsp_value !== expected_values[0]) begin
               $error("value mismatch: expected %h, actual %h",
                      expected_values[0], rsp_value);
               fail_count++;
               void'(expected_values.pop_front());
            end else begin
               void'(expected_values.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_RESEED)
               reseed_lags(req_seed);
            else
               predict_draw();
         end
      end
      draws_pending = expected_values.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives draw and reseed requests into the lagged generator under random
// idling on both channels, rewrites the warmup register between phases, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import slrg_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam logic [CSR_ADDR_W-1:0] WARMUP_ADDR = CSR_ADDR_W'(4 * REG_INIT_VALUE);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_opcode;
   logic [31:0]           req_seed;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [31:0]           rsp_value;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int   fail_count;
   int   draws_pending;
   int   quiet_cycles;
   logic no_gaps;
   int   hold_requests;

   always #5 clock = ~clock;

   subtractive_lagged_random_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_seed    (req_seed),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   slrg_draw_check draw_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_seed      (req_seed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .fail_count    (fail_count),
      .draws_pending (draws_pending)
   );

   // Watchdog: any transfer on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result receiver. A requested hold is folded into the next gap so that
   // ready gets a single assignment per falling edge.
   initial begin
      int gap;
      int holds_served;
      rsp_ready = 1'b0;
      holds_served = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         if (hold_requests != holds_served) begin
            gap = gap + HOLD_CYCLES;
            holds_served++;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic logic [31:0] fraction_pattern();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic offer_item(input opcode_type op, input logic [31:0] seed);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_seed   <= seed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drains every expected result, then gives a reseed still in progress
   // time to finish before the block is touched again.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(negedge clock);
      while (draws_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= WARMUP_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly reseed-then-draw runs long enough to wrap the table, with the
   // occasional run that skips the reseed or draws nothing. The hold and the
   // drain fire at the first draw once the item count has reached them.
   task automatic run_phase(input int item_count, input int hold_at, input int drain_at);
      int   sent;
      int   run_len;
      logic hold_done;
      logic drain_done;
      sent       = 0;
      hold_done  = (hold_at < 0);
      drain_done = (drain_at < 0);
      while (sent < item_count) begin
         if ($urandom_range(0, 7) != 0) begin
            offer_item(OP_RESEED, fraction_pattern());
            sent++;
         end
         run_len = $urandom_range(0, 130);
         while (run_len > 0 && sent < item_count) begin
            if (!hold_done && sent >= hold_at) begin
               hold_requests++;
               hold_done = 1'b1;
            end
            if (!drain_done && sent >= drain_at) begin
               drain_done = 1'b1;
               req_valid <= 1'b0;
               @(negedge clock);
               while (draws_pending != 0) @(negedge clock);
            end
            offer_item(OP_DRAW, $urandom);
            sent++;
            run_len--;
         end
      end
   endtask

   initial begin
      logic [31:0] warmup_values [0:3];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_DRAW;
      req_seed      = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      no_gaps       = 1'b0;
      hold_requests = 0;
      warmup_values[0] = 32'h0000_0000;
      warmup_values[1] = 32'hFFFF_FFFF;
      warmup_values[2] = $urandom;
      warmup_values[3] = 32'h8000_0000;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset warmup value. The first draws hit the
      // all-zero table that reset leaves behind.
      csr_access(1'b0, '0);
      offer_item(OP_DRAW, 32'h0000_0000);
      offer_item(OP_DRAW, 32'hFFFF_FFFF);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_RESEED, 32'h0000_0000);
      offer_item(OP_DRAW, 32'hFFFF_FFFF);
      offer_item(OP_DRAW, 32'h0000_0000);
      offer_item(OP_RESEED, 32'hFFFF_FFFF);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_RESEED, 32'h0000_0001);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_RESEED, 32'h8000_0000);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_RESEED, 32'h7FFF_FFFF);
      offer_item(OP_RESEED, $urandom);
      offer_item(OP_DRAW, $urandom);
      offer_item(OP_DRAW, $urandom);

      run_phase(130, 40, -1);
      for (int p = 0; p < 4; p++) begin
         settle_block();
         csr_access(1'b1, warmup_values[p]);
         csr_access(1'b0, '0);
         no_gaps = (p == 2);
         run_phase(140, -1, (p == 1) ? 60 : -1);
      end
      no_gaps = 1'b0;

      settle_block();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/slrg_pkg.sv
rtl/slrg_lag_mem.sv
rtl/slrg_ctrl.sv
rtl/subtractive_lagged_random_generator.sv
tb/slrg_draw_check.sv
tb/testbench.sv
